### hw/rtl/lers_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lers_pkg
// Shared types and constants of the lane edge row scanner.
// ----------------------------------------------------------------------------
package lers_pkg;

    localparam int COL_W   = 10;
    localparam int PIX_W   = 8;
    localparam int WIDTH_W = 11;
    localparam int OFF_W   = 10;
    localparam int MID_W   = 11;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam int ROW_WIDTH_LIMIT = 1024;

    localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET     = 11'd620;
    localparam logic [OFF_W-1:0]   REGION_OFFSET_RESET = 10'd9;
    localparam logic [COL_W-1:0]   START_RESET         = 10'd310;

    localparam logic CFG_IDX_ROW_WIDTH     = 1'b0;
    localparam logic CFG_IDX_REGION_OFFSET = 1'b1;

    localparam int IN_TDATA_W  = 24;
    localparam int RES_W       = 77;
    localparam int OUT_TDATA_W = 80;

    // One classified pixel as it sits in the queue
    typedef struct packed {
        logic             dark;
        logic             bottom;
        logic             fend;
        logic [COL_W-1:0] column;
    } t_pix;

    // Declared from the top bit down, so top_left_edge lands at bit 0
    typedef struct packed {
        logic [MID_W-1:0] lane_middle;
        logic [MID_W-1:0] bottom_middle;
        logic [MID_W-1:0] top_middle;
        logic             bottom_right_seen;
        logic             bottom_left_seen;
        logic             top_right_seen;
        logic             top_left_seen;
        logic [COL_W-1:0] bottom_right_edge;
        logic [COL_W-1:0] bottom_left_edge;
        logic [COL_W-1:0] top_right_edge;
        logic [COL_W-1:0] top_left_edge;
    } t_result;

endpackage

### hw/rtl/lane_edge_row_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lane_edge_row_scanner
// Finds lane edges around a tracked start column in two scan rows.
// ----------------------------------------------------------------------------
// Pixels of the top and bottom scan rows enter on the s_axis stream, one
// beat per pixel: tdata carries column and mask value, tuser picks the row
// (1 = bottom), tlast marks the last pixel of the frame. Only the tlast beat
// produces a result on m_axis with the left and right edges of both rows,
// their seen flags, the middles of both rows and the lane middle. Each row's
// start column then moves to the midpoint of the edges just found.
// Throughput is one pixel per cycle while s_axis_tready is high. With the
// queue empty and the output free, the tlast beat is written into the intake
// queue and then passes through the search into the m_axis output register.
// The output register holds a result while m_axis_tready is low; pixels keep
// flowing into the search until a second frame end reaches it, and then the
// queue fills and s_axis_tready drops.
// Reset empties the queue, drops the output, restores row_width 620,
// region_offset 9 and both start columns to 310. The cfg port writes a register;
// the user must use it only while the stream is idle, as the block never checks.
// ----------------------------------------------------------------------------
module lane_edge_row_scanner #(
    parameter int MAX_ROW_WIDTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_addr,
    input  logic [lers_pkg::WIDTH_W-1:0]     i_cfg_wdata,
    // pixel stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: column[9:0], pixel[17:10], zero pad[23:18]
    input  logic [lers_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: row_is_bottom
    input  logic                             s_axis_tuser,
    // tlast: frame_end
    input  logic                             s_axis_tlast,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: top_left_edge[9:0], top_right_edge[19:10], bottom_left_edge[29:20],
    // bottom_right_edge[39:30], top_left_seen[40], top_right_seen[41],
    // bottom_left_seen[42], bottom_right_seen[43], top_middle[54:44],
    // bottom_middle[65:55], lane_middle[76:66], zero pad[79:77]
    output logic [lers_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import lers_pkg::*;

    localparam int WidthCap = (MAX_ROW_WIDTH < ROW_WIDTH_LIMIT) ? MAX_ROW_WIDTH
                                                                : ROW_WIDTH_LIMIT;

    logic [WIDTH_W-1:0] r_row_width;
    logic [OFF_W-1:0]   r_region_offset;
    logic [WIDTH_W-1:0] w_eff_width;

    t_pix    w_front_pix;
    t_pix    w_q_data;
    logic    w_q_full;
    logic    w_q_valid;
    logic    w_q_pop;
    logic    w_push;
    t_result w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width     <= ROW_WIDTH_RESET;
            r_region_offset <= REGION_OFFSET_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_IDX_ROW_WIDTH:     r_row_width     <= i_cfg_wdata;
                CFG_IDX_REGION_OFFSET: r_region_offset <= i_cfg_wdata[OFF_W-1:0];
                default:               r_row_width     <= r_row_width;
            endcase
        end
    end

    // clamp to the supported row length, treat zero as one pixel
    always_comb begin
        if (r_row_width > WIDTH_W'(WidthCap)) begin
            w_eff_width = WIDTH_W'(WidthCap);
        end else if (r_row_width == '0) begin
            w_eff_width = WIDTH_W'(1);
        end else begin
            w_eff_width = r_row_width;
        end
    end

    assign s_axis_tready = !w_q_full;
    assign w_push        = s_axis_tvalid && !w_q_full;

    lers_front u_front (
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_tlast     (s_axis_tlast),
        .i_eff_width (w_eff_width),
        .o_pix       (w_front_pix)
    );

    lers_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_pix),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    lers_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_eff_width     (w_eff_width),
        .i_region_offset (r_region_offset),
        .i_q_valid       (w_q_valid),
        .i_q_data        (w_q_data),
        .o_q_pop         (w_q_pop),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_result        (w_result)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-RES_W){1'b0}}, w_result};

endmodule

### hw/rtl/lers_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lers_front
// Pixel intake: unpacks a beat and marks dark pixels inside the row.
// ----------------------------------------------------------------------------
module lers_front (
    input  logic [lers_pkg::IN_TDATA_W-1:0] i_tdata,
    input  logic                            i_tuser,
    input  logic                            i_tlast,
    input  logic [lers_pkg::WIDTH_W-1:0]    i_eff_width,
    output lers_pkg::t_pix                  o_pix
);
    import lers_pkg::*;

    logic [COL_W-1:0] w_column;
    logic [PIX_W-1:0] w_pixel;

    assign w_column = i_tdata[COL_W-1:0];
    assign w_pixel  = i_tdata[COL_W+PIX_W-1:COL_W];

    always_comb begin
        o_pix.column = w_column;
        o_pix.bottom = i_tuser;
        o_pix.fend   = i_tlast;
        // drop columns past the row end from the search
        o_pix.dark   = (w_pixel == '0) && ({1'b0, w_column} < i_eff_width);
    end

endmodule

### hw/rtl/lers_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lers_queue
// Short register queue between pixel intake and the edge search.
// ----------------------------------------------------------------------------
module lers_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lers_pkg::t_pix i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output lers_pkg::t_pix o_data
);
    import lers_pkg::*;

    t_pix              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hw/rtl/lers_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lers_back
// Edge search: tracks the nearest dark pixels around each row's start
// column and builds the frame result into the output register.
// ----------------------------------------------------------------------------
module lers_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [lers_pkg::WIDTH_W-1:0] i_eff_width,
    input  logic [lers_pkg::OFF_W-1:0]   i_region_offset,
    input  logic                         i_q_valid,
    input  lers_pkg::t_pix               i_q_data,
    output logic                         o_q_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output lers_pkg::t_result            o_result
);
    import lers_pkg::*;

    logic [COL_W-1:0] r_top_start;
    logic [COL_W-1:0] r_bot_start;
    logic [COL_W-1:0] r_tl;
    logic [COL_W-1:0] r_tr;
    logic [COL_W-1:0] r_bl;
    logic [COL_W-1:0] r_br;
    logic [3:0]       r_flags;
    logic             r_out_valid;
    t_result          r_out;

    logic [COL_W-1:0] n_tl, n_tr, n_bl, n_br;
    logic [3:0]       n_flags;
    logic [COL_W-1:0] n_top_start, n_bot_start;
    t_result          n_out;

    logic             w_out_free;
    logic             w_top, w_bot;
    logic             w_tl_hit, w_tr_hit, w_bl_hit, w_br_hit;
    logic [COL_W-1:0] w_last;
    logic [COL_W-1:0] w_tl, w_tr, w_bl, w_br;
    logic [COL_W:0]   w_top_sum, w_bot_sum;
    logic [MID_W-1:0] w_tm, w_bm;
    logic [MID_W:0]   w_lane_sum;

    assign w_out_free = !r_out_valid || i_ready;
    // hold a frame end in the queue until the output slot frees up
    assign o_q_pop    = i_q_valid && (!i_q_data.fend || w_out_free);

    assign w_top = i_q_data.dark && !i_q_data.bottom;
    assign w_bot = i_q_data.dark && i_q_data.bottom;

    always_comb begin
        w_tl_hit = w_top && (i_q_data.column <= r_top_start)
                   && (!r_flags[0] || (i_q_data.column > r_tl));
        w_tr_hit = w_top && (i_q_data.column >= r_top_start)
                   && (!r_flags[1] || (i_q_data.column < r_tr));
        w_bl_hit = w_bot && (i_q_data.column <= r_bot_start)
                   && (!r_flags[2] || (i_q_data.column > r_bl));
        w_br_hit = w_bot && (i_q_data.column >= r_bot_start)
                   && (!r_flags[3] || (i_q_data.column < r_br));

        n_tl    = w_tl_hit ? i_q_data.column : r_tl;
        n_tr    = w_tr_hit ? i_q_data.column : r_tr;
        n_bl    = w_bl_hit ? i_q_data.column : r_bl;
        n_br    = w_br_hit ? i_q_data.column : r_br;
        n_flags = r_flags | {w_br_hit, w_bl_hit, w_tr_hit, w_tl_hit};

        w_last = COL_W'(i_eff_width - 1'b1);
        w_tl   = n_flags[0] ? n_tl : '0;
        w_tr   = n_flags[1] ? n_tr : w_last;
        w_bl   = n_flags[2] ? n_bl : '0;
        w_br   = n_flags[3] ? n_br : w_last;

        w_top_sum   = {1'b0, w_tl} + {1'b0, w_tr};
        w_bot_sum   = {1'b0, w_bl} + {1'b0, w_br};
        n_top_start = w_top_sum[COL_W:1];
        n_bot_start = w_bot_sum[COL_W:1];
        w_tm        = {1'b0, i_region_offset} + {1'b0, n_top_start};
        w_bm        = {1'b0, i_region_offset} + {1'b0, n_bot_start};
        w_lane_sum  = {1'b0, w_tm} + {1'b0, w_bm};

        n_out.top_left_edge     = w_tl;
        n_out.top_right_edge    = w_tr;
        n_out.bottom_left_edge  = w_bl;
        n_out.bottom_right_edge = w_br;
        n_out.top_left_seen     = n_flags[0];
        n_out.top_right_seen    = n_flags[1];
        n_out.bottom_left_seen  = n_flags[2];
        n_out.bottom_right_seen = n_flags[3];
        n_out.top_middle        = w_tm;
        n_out.bottom_middle     = w_bm;
        n_out.lane_middle       = w_lane_sum[MID_W:1];
    end

    // tracks and result are only read behind their flags / valid
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_tl <= n_tl;
            r_tr <= n_tr;
            r_bl <= n_bl;
            r_br <= n_br;
            if (i_q_data.fend) begin
                r_out <= n_out;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_start <= START_RESET;
            r_bot_start <= START_RESET;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                if (i_q_data.fend) begin
                    r_top_start <= n_top_start;
                    r_bot_start <= n_bot_start;
                    r_flags     <= '0;
                end else begin
                    r_flags <= n_flags;
                end
            end
            if (o_q_pop && i_q_data.fend) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

### hw/rtl/lers_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lers_checker
// Port-level checks of the lane edge row scanner, bound to the top level.
// ----------------------------------------------------------------------------
module lers_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [lers_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import lers_pkg::*;

    t_result        w_res;
    logic [MID_W:0] w_mid_sum;
    logic [MID_W:0] w_lane_x2;

    assign w_res     = m_axis_tdata[RES_W-1:0];
    assign w_mid_sum = {1'b0, w_res.top_middle} + {1'b0, w_res.bottom_middle};
    assign w_lane_x2 = {w_res.lane_middle, 1'b0};

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // top left edge never lies right of the top right edge when both were found
    a_top_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.top_left_seen && w_res.top_right_seen
        |-> w_res.top_left_edge <= w_res.top_right_edge)
        else $error("top edges out of order");

    a_left_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !w_res.bottom_left_seen |-> w_res.bottom_left_edge == '0)
        else $error("unseen bottom left edge not at column zero");

    a_lane_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_lane_x2 == w_mid_sum) || (w_lane_x2 + 1'b1 == w_mid_sum))
        else $error("lane middle is not the midpoint of the row middles");

endmodule

bind lane_edge_row_scanner lers_checker u_lers_checker (.*);
